// ===== src/lrg_pkg.sv =====
package lrg_pkg;

  // Field widths
  localparam int RANGE_W   = 16;
  localparam int BEAM_W    = 12;
  localparam int ANG_W     = 16;
  localparam int TRIG_W    = 15;               // |sin| magnitude, Q0.15
  localparam int SCALE_W   = 24;
  localparam int SCALE_FRAC = 20;
  localparam int TRIG_FRAC  = 15;
  localparam int MAG_W     = RANGE_W + TRIG_W + SCALE_W - SCALE_FRAC - TRIG_FRAC;

  // Image geometry
  localparam int IMAGE_SIDE = 512;
  localparam int MAX_BEAMS  = 4096;
  localparam int HALF_SIDE  = IMAGE_SIDE / 2;
  localparam int PIX_W      = $clog2(IMAGE_SIDE);
  localparam int COORD_W    = MAG_W + 2;

  // Quarter-wave polynomial
  localparam logic [15:0] TRIG_A   = 16'd51472;
  localparam logic [14:0] TRIG_B   = 15'd21024;
  localparam logic [11:0] TRIG_C   = 12'd2320;
  localparam logic [14:0] QUARTER  = 15'd16384;
  localparam logic [TRIG_W-1:0] TRIG_MAX = 15'd32767;

  // Pipeline shape
  localparam int SINE_STAGES  = 4;
  localparam int SCALE_STAGES = 2;
  localparam int LATENCY      = 2 + SINE_STAGES + SCALE_STAGES + 1;

  // Register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd4;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [BEAM_W-1:0]  beam_index;
  } lrg_in_t;

  typedef struct packed {
    logic             hit;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } lrg_out_t;

  typedef struct packed {
    logic vld;
    logic ok;   // range window and beam index passed
  } lrg_ctl_t;

endpackage

// ===== src/lrg_sine.sv =====
// Four-stage quarter-wave sine: magnitude and sign of a 16-bit binary angle.
module lrg_sine import lrg_pkg::*; (
  input  logic              clk,
  input  logic [ANG_W-1:0]  angle,
  output logic [TRIG_W-1:0] mag,
  output logic              neg
);

  // stage A: fold into first quadrant, square
  logic [14:0] g_nxt;
  logic [15:0] z_nxt;
  logic [31:0] zz;
  logic [15:0] z_a_r, z2_a_r;
  logic        neg_a_r;

  always_comb begin
    g_nxt = angle[14] ? (QUARTER - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    z_nxt = {g_nxt, 1'b0};
    zz    = 32'(z_nxt) * 32'(z_nxt);
  end

  always_ff @(posedge clk) begin
    z_a_r   <= z_nxt;
    z2_a_r  <= zz[30:15];
    neg_a_r <= angle[15];
  end

  // stage B: t1 = B - C*z2
  logic [27:0] cz;
  logic [14:0] t1_b_r;
  logic [15:0] z_b_r, z2_b_r;
  logic        neg_b_r;

  assign cz = 28'(TRIG_C) * 28'(z2_a_r);

  always_ff @(posedge clk) begin
    t1_b_r  <= TRIG_B - 15'(cz[27:15]);
    z_b_r   <= z_a_r;
    z2_b_r  <= z2_a_r;
    neg_b_r <= neg_a_r;
  end

  // stage C: t2 = A - t1*z2
  logic [30:0] tz;
  logic [15:0] t2_c_r, z_c_r;
  logic        neg_c_r;

  assign tz = 31'(t1_b_r) * 31'(z2_b_r);

  always_ff @(posedge clk) begin
    t2_c_r  <= TRIG_A - tz[30:15];
    z_c_r   <= z_b_r;
    neg_c_r <= neg_b_r;
  end

  // stage D: m = t2*z, saturate; zero carries no sign
  logic [31:0]       q;
  logic [TRIG_W-1:0] m_nxt;
  logic [TRIG_W-1:0] mag_r;
  logic              neg_r;

  always_comb begin
    q     = 32'(t2_c_r) * 32'(z_c_r);
    m_nxt = (q[31:15] > 17'(TRIG_MAX)) ? TRIG_MAX : q[29:15];
  end

  always_ff @(posedge clk) begin
    mag_r <= m_nxt;
    neg_r <= neg_c_r && (m_nxt != '0);
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

// ===== src/lrg_scale.sv =====
// Two-stage offset magnitude: (range * |trig| * scale) >> 35.
module lrg_scale import lrg_pkg::*; (
  input  logic               clk,
  input  logic [RANGE_W-1:0] range_mm,
  input  logic [TRIG_W-1:0]  trig,
  input  logic               neg_i,
  input  logic [SCALE_W-1:0] scale_q20,
  output logic [MAG_W-1:0]   mag,
  output logic               neg_o
);

  localparam int P_W    = RANGE_W + TRIG_W;
  localparam int PROD_W = P_W + SCALE_W;
  localparam int SHIFT  = SCALE_FRAC + TRIG_FRAC;

  logic [P_W-1:0]    p_r;
  logic              neg_p_r;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;

  always_ff @(posedge clk) begin
    p_r     <= P_W'(range_mm) * P_W'(trig);
    neg_p_r <= neg_i;
  end

  assign prod = PROD_W'(p_r) * PROD_W'(scale_q20);

  always_ff @(posedge clk) begin
    mag_r <= prod[PROD_W-1:SHIFT];
    neg_r <= neg_p_r;
  end

  assign mag   = mag_r;
  assign neg_o = neg_r;

endmodule

// ===== src/lidar_range_to_grid_pixel.sv =====
// Channel   Ports                                     Transaction
// --------  ----------------------------------------  ---------------------------------
// input     start, busy, in_data (lrg_in_t)           start & !busy at a rising edge
// result    out_strobe, out_data (lrg_out_t)          out_strobe, one cycle, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_wdata cfg_valid & cfg_ready
//
// One sample per clock; each result passes through the pipeline registers
// in order: input register, angle multiply, four quarter-wave polynomial
// stages, two offset multiply stages, output stage.
// busy stays low and cfg_ready stays high: nothing in the block ever holds off.
// rst_n (synchronous) clears the valid bits and loads register reset values.
module lidar_range_to_grid_pixel import lrg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lrg_in_t              in_data,
  output logic                 out_strobe,
  output lrg_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_wdata
);

  localparam int CTL_DEPTH = SINE_STAGES + SCALE_STAGES;

  // ---------------------------------------------------------------------------
  // Configuration registers. Software must write them only while the pipe is
  // empty; the block does not enforce this. Every stage reads them directly.
  // ---------------------------------------------------------------------------
  logic [RANGE_W-1:0] range_min_r, range_max_r;
  logic [ANG_W-1:0]   angle_start_r, angle_step_r;
  logic [SCALE_W-1:0] scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r   <= '0;
      range_max_r   <= '1;
      angle_start_r <= '0;
      angle_step_r  <= '0;
      scale_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RANGE_MIN:   range_min_r   <= cfg_wdata[RANGE_W-1:0];
        REG_RANGE_MAX:   range_max_r   <= cfg_wdata[RANGE_W-1:0];
        REG_ANGLE_START: angle_start_r <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[ANG_W-1:0];
        REG_SCALE:       scale_r       <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture the sample.
  // ---------------------------------------------------------------------------
  logic    accept;
  logic    in_vld_r;
  lrg_in_t in_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: beam angle (wraps mod one turn) and acceptance window.
  // ---------------------------------------------------------------------------
  logic [BEAM_W+ANG_W-1:0] beam_prod;
  logic [ANG_W-1:0]        angle_nxt, angle_r;
  lrg_ctl_t                ctl_nxt, ctl1_r;
  logic [RANGE_W-1:0]      range1_r;

  always_comb begin
    beam_prod   = (BEAM_W+ANG_W)'(in_r.beam_index) * (BEAM_W+ANG_W)'(angle_step_r);
    angle_nxt   = angle_start_r + beam_prod[ANG_W-1:0];
    ctl_nxt.vld = in_vld_r;
    ctl_nxt.ok  = (17'(in_r.beam_index) < 17'(MAX_BEAMS)) &&
                  (in_r.range_mm >= range_min_r) &&
                  (in_r.range_mm <= range_max_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl1_r <= '0;
    else        ctl1_r <= ctl_nxt;
  end

  always_ff @(posedge clk) begin
    angle_r  <= angle_nxt;
    range1_r <= in_r.range_mm;
  end

  // ---------------------------------------------------------------------------
  // Control and range delay lines, running alongside the arithmetic lanes.
  // ---------------------------------------------------------------------------
  lrg_ctl_t           ctl_r   [CTL_DEPTH];
  logic [RANGE_W-1:0] range_r [SINE_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CTL_DEPTH; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= ctl1_r;
      for (int i = 1; i < CTL_DEPTH; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    range_r[0] <= range1_r;
    for (int i = 1; i < SINE_STAGES; i++) range_r[i] <= range_r[i-1];
  end

  // ---------------------------------------------------------------------------
  // Two lanes: x follows cos (angle plus a quarter turn), y follows sin.
  // ---------------------------------------------------------------------------
  logic [ANG_W-1:0]  angle_cos;
  logic [TRIG_W-1:0] trig_x, trig_y;
  logic              tneg_x, tneg_y;
  logic [MAG_W-1:0]  mag_x, mag_y;
  logic              neg_x, neg_y;

  assign angle_cos = angle_r + ANG_W'(QUARTER);

  lrg_sine u_sine_x (.clk(clk), .angle(angle_cos), .mag(trig_x), .neg(tneg_x));
  lrg_sine u_sine_y (.clk(clk), .angle(angle_r),   .mag(trig_y), .neg(tneg_y));

  lrg_scale u_scale_x (
    .clk(clk), .range_mm(range_r[SINE_STAGES-1]), .trig(trig_x), .neg_i(tneg_x),
    .scale_q20(scale_r), .mag(mag_x), .neg_o(neg_x)
  );
  lrg_scale u_scale_y (
    .clk(clk), .range_mm(range_r[SINE_STAGES-1]), .trig(trig_y), .neg_i(tneg_y),
    .scale_q20(scale_r), .mag(mag_y), .neg_o(neg_y)
  );

  // ---------------------------------------------------------------------------
  // Output stage: re-center, bounds check, zero the pixel on a miss.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] cx, cy;
  logic               hit_nxt;
  lrg_out_t           out_nxt, out_r;
  logic               out_vld_r;

  always_comb begin
    cx = neg_x ? (COORD_W'(HALF_SIDE) - COORD_W'(mag_x)) : (COORD_W'(HALF_SIDE) + COORD_W'(mag_x));
    cy = neg_y ? (COORD_W'(HALF_SIDE) - COORD_W'(mag_y)) : (COORD_W'(HALF_SIDE) + COORD_W'(mag_y));
    // negative values set the top bit, so one all-zero test covers both ends
    hit_nxt = ctl_r[CTL_DEPTH-1].ok &&
              (cx[COORD_W-1:PIX_W] == '0) && (cy[COORD_W-1:PIX_W] == '0);
    out_nxt.hit     = hit_nxt;
    out_nxt.pixel_x = hit_nxt ? cx[PIX_W-1:0] : '0;
    out_nxt.pixel_y = hit_nxt ? cy[PIX_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= ctl_r[CTL_DEPTH-1].vld;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

// ===== src/lrg_checker.sv =====
module lrg_checker import lrg_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input lrg_out_t out_data
);

  // every accepted transaction yields exactly one result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("accepted transaction produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.hit) |-> (out_data.pixel_x == '0 && out_data.pixel_y == '0))
    else $error("miss carries a nonzero pixel");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

bind lidar_range_to_grid_pixel lrg_checker u_lrg_checker (.*);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrg_pkg::*;

  // Quarter-wave sine polynomial, kept separate from the package copy so a
  // bad package constant shows up as a mismatch.
  localparam longint unsigned POLY_A = 64'd51472;
  localparam longint unsigned POLY_B = 64'd21024;
  localparam longint unsigned POLY_C = 64'd2320;
  localparam longint unsigned Q15_MAX = 64'd32767;

  // Indexes past the register map; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Cycles with no transaction of any kind before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // One entry of the stimulus schedule: a sample or a register write.
  typedef struct {
    bit                   is_cfg;
    lrg_in_t              sample;
    logic [CFG_IDX_W-1:0] idx;
    logic [SCALE_W-1:0]   wdata;
    int                   idle_pct;
  } sched_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lrg_in_t in_data = '0;
  logic out_strobe;
  lrg_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0] cfg_wdata = '0;

  sched_op_t sched_q[$];
  lrg_out_t pixel_q[$];
  int mismatches = 0;
  int stall_cycles = 0;
  int sender_idle_pct = 7;

  // Shadow copy of the register file, updated on each accepted write.
  logic [15:0] shd_range_min = 16'd0;
  logic [15:0] shd_range_max = 16'hFFFF;
  logic [15:0] shd_angle_start = 16'd0;
  logic [15:0] shd_angle_step = 16'd0;
  logic [SCALE_W-1:0] shd_scale = '0;

  always #6 clk = ~clk;

  lidar_range_to_grid_pixel DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // |sin| over a quarter turn, g = 0..16384, Q0.15, all shifts truncate.
  function automatic longint unsigned quarter_mag(input logic [14:0] g);
    longint unsigned z, z2, r;
    z = g;
    z = z << 1;
    z2 = (z * z) >> 15;
    r = (POLY_C * z2) >> 15;
    r = POLY_B - r;
    r = (r * z2) >> 15;
    r = POLY_A - r;
    r = (r * z) >> 15;
    if (r > Q15_MAX) r = Q15_MAX;
    return r;
  endfunction

  // Sine of a binary angle as magnitude plus sign; odd quadrants mirror.
  function automatic longint unsigned bam_sine(input logic [15:0] a, output bit neg);
    logic [14:0] g;
    longint unsigned m;
    if (a[14]) g = 15'd16384 - {1'b0, a[13:0]};
    else g = {1'b0, a[13:0]};
    m = quarter_mag(g);
    neg = a[15] && (m != 0);
    return m;
  endfunction

  // One axis: image center plus range*trig*scale, truncated toward zero.
  function automatic longint axis_coord(input logic [15:0] rng, input logic [15:0] a);
    bit neg;
    longint unsigned m, prod;
    longint off;
    m = bam_sine(a, neg);
    prod = rng;
    prod = prod * m;
    prod = prod * shd_scale;
    prod = prod >> 35;
    off = neg ? -longint'(prod) : longint'(prod);
    return off + HALF_SIDE;
  endfunction

  function automatic lrg_out_t predict_pixel(input lrg_in_t s);
    lrg_out_t res;
    logic [15:0] ang;
    longint x, y;
    res = '0;
    if (int'(s.beam_index) < MAX_BEAMS && s.range_mm >= shd_range_min &&
        s.range_mm <= shd_range_max) begin
      // 16-bit context: beam angle wraps modulo one turn
      ang = shd_angle_start + s.beam_index * shd_angle_step;
      x = axis_coord(s.range_mm, ang + 16'd16384);   // cos axis
      y = axis_coord(s.range_mm, ang);
      if (x >= 0 && x < IMAGE_SIDE && y >= 0 && y < IMAGE_SIDE) begin
        res.hit = 1'b1;
        res.pixel_x = x[PIX_W-1:0];
        res.pixel_y = y[PIX_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic void write_shadow(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [SCALE_W-1:0] val);
    case (idx)
      REG_RANGE_MIN:   shd_range_min = val[15:0];
      REG_RANGE_MAX:   shd_range_max = val[15:0];
      REG_ANGLE_START: shd_angle_start = val[15:0];
      REG_ANGLE_STEP:  shd_angle_step = val[15:0];
      REG_SCALE:       shd_scale = val;
      default: ;       // unmapped index, dropped
    endcase
  endfunction

  task automatic queue_sample(input logic [15:0] rng, input logic [11:0] beam);
    sched_op_t op;
    op.is_cfg = 1'b0;
    op.sample.range_mm = rng;
    op.sample.beam_index = beam;
    op.idx = '0;
    op.wdata = '0;
    op.idle_pct = sender_idle_pct;
    sched_q = {sched_q, op};
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
    sched_op_t op;
    op.is_cfg = 1'b1;
    op.sample = '0;
    op.idx = idx;
    op.wdata = val;
    op.idle_pct = 0;
    sched_q = {sched_q, op};
  endtask

  // Driver: pops the schedule. A register write waits until every expected
  // pixel has come back, so the pipeline is empty when the settings change.
  // Next values go to locals first so each output gets one NBA per edge.
  always @(posedge clk) begin : driver
    logic nxt_start, nxt_cfg;
    sched_op_t head;
    nxt_start = start;
    nxt_cfg = cfg_valid;
    if (!rst_n) begin
      nxt_start = 1'b0;
      nxt_cfg = 1'b0;
    end else begin
      if (start && !busy) begin
        pixel_q = {pixel_q, predict_pixel(in_data)};
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        write_shadow(cfg_index, cfg_wdata);
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && sched_q.size() != 0) begin
        head = sched_q[0];
        if (head.is_cfg) begin
          if (pixel_q.size() == 0) begin
            void'(sched_q.pop_front());
            cfg_index <= head.idx;
            cfg_wdata <= head.wdata;
            nxt_cfg = 1'b1;
          end
        end else if ($urandom_range(99) >= head.idle_pct) begin
          void'(sched_q.pop_front());
          in_data <= head.sample;
          nxt_start = 1'b1;
        end
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // Monitor: every strobe must match the oldest expected pixel.
  always @(posedge clk) begin : monitor
    lrg_out_t exp_pix;
    if (rst_n && out_strobe) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result transaction: hit %0b x %0d y %0d",
               out_data.hit, out_data.pixel_x, out_data.pixel_y);
        mismatches++;
      end else begin
        exp_pix = pixel_q.pop_front();
        if (out_data.hit !== exp_pix.hit) begin
          $error("hit: expected %0b, actual %0b", exp_pix.hit, out_data.hit);
          mismatches++;
        end
        if (out_data.pixel_x !== exp_pix.pixel_x) begin
          $error("pixel_x: expected %0d, actual %0d", exp_pix.pixel_x, out_data.pixel_x);
          mismatches++;
        end
        if (out_data.pixel_y !== exp_pix.pixel_y) begin
          $error("pixel_y: expected %0d, actual %0d", exp_pix.pixel_y, out_data.pixel_y);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Random settings for one block of samples; 16-bit registers get junk in
  // the upper byte of wdata to check that it is masked.
  task automatic plan_settings(output logic [15:0] lo, output logic [15:0] hi);
    int r;
    longint nominal;
    logic [SCALE_W-1:0] scl;
    hi = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 16));
    r = $urandom_range(99);
    if (r < 60) lo = 16'($urandom_range(hi / 4, 0));
    else if (r < 85) lo = 16'd0;
    else lo = 16'($urandom_range(65535, 0));     // may leave the window empty
    // nominal: the full window just fits across the image
    nominal = (longint'(IMAGE_SIDE) << SCALE_FRAC) / (2 * longint'(hi));
    if (nominal > 24'hFFFFFF) nominal = 24'hFFFFFF;
    r = $urandom_range(99);
    if (r < 75) scl = nominal[SCALE_W-1:0];
    else if (r < 90) scl = 24'((nominal * $urandom_range(4, 1)) / 2 > 24'hFFFFFF ?
                               24'hFFFFFF : (nominal * $urandom_range(4, 1)) / 2);
    else scl = 24'($urandom_range(24'hFFFFFF, 0));
    queue_write(REG_RANGE_MIN, {8'($urandom), lo});
    queue_write(REG_RANGE_MAX, {8'($urandom), hi});
    queue_write(REG_ANGLE_START, {8'($urandom), 16'($urandom)});
    queue_write(REG_ANGLE_STEP, ($urandom_range(3) == 0) ? 24'd16 :
                {8'($urandom), 16'($urandom)});
    queue_write(REG_SCALE, scl);
    if ($urandom_range(3) == 0) queue_write(REG_SPARE_6, 24'($urandom));
  endtask

  initial begin : stimulus
    logic [15:0] lo, hi, rng;
    int r;
    int idle_set[3];
    idle_set = '{7, 58, 0};

    // Directed: reset settings have zero scale, so every sample lands on
    // the image center.
    sender_idle_pct = idle_set[0];
    queue_sample(16'd0, 12'd0);
    queue_sample(16'hFFFF, 12'hFFF);
    queue_sample(16'd12345, 12'd2048);
    // writes to unmapped indexes must leave the map alone
    queue_write(REG_SPARE_5, 24'hFFFFFF);
    queue_write(REG_SPARE_6, 24'h5A5A5A);
    queue_write(REG_SPARE_7, 24'hA5A5A5);
    queue_sample(16'd500, 12'd100);
    // window 1000..20000 mm, full scan over 4096 beams, nominal scale
    queue_write(REG_RANGE_MIN, 24'd1000);
    queue_write(REG_RANGE_MAX, 24'd20000);
    queue_write(REG_ANGLE_START, 24'd0);
    queue_write(REG_ANGLE_STEP, 24'd16);
    queue_write(REG_SCALE, 24'd13422);
    queue_sample(16'd999, 12'd0);       // just below the window
    queue_sample(16'd1000, 12'd0);
    queue_sample(16'd20000, 12'd0);     // right edge of the image
    queue_sample(16'd20001, 12'd0);     // just above the window
    queue_sample(16'd20000, 12'd1024);  // quadrant boundaries
    queue_sample(16'd20000, 12'd2048);
    queue_sample(16'd20000, 12'd3072);
    queue_sample(16'd20000, 12'd512);
    queue_sample(16'hFFFF, 12'hFFF);
    // empty window: min above max rejects everything
    queue_write(REG_RANGE_MIN, 24'd5000);
    queue_write(REG_RANGE_MAX, 24'd4000);
    queue_sample(16'd4500, 12'd10);
    queue_sample(16'd5000, 12'd10);
    queue_sample(16'd4000, 12'd10);
    // register extremes, maximum scale throws long ranges off the image
    queue_write(REG_RANGE_MIN, 24'hFF0000);  // upper byte masked, reads 0
    queue_write(REG_RANGE_MAX, 24'hFFFFFF);
    queue_write(REG_ANGLE_START, 24'h00FFFF);
    queue_write(REG_ANGLE_STEP, 24'h00FFFF);
    queue_write(REG_SCALE, 24'hFFFFFF);
    queue_sample(16'd0, 12'd0);
    queue_sample(16'hFFFF, 12'd0);
    queue_sample(16'd1, 12'd1);
    queue_write(REG_SCALE, 24'd4096);
    queue_sample(16'hFFFF, 12'd0);
    queue_sample(16'hFFFF, 12'hFFF);
    queue_sample(16'd32768, 12'd1234);

    // Random: three idle profiles, four settings each, about 42 samples per
    // setting. Most samples sit inside the window so the trig path is used.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_set[ph];
      for (int blk = 0; blk < 4; blk++) begin
        plan_settings(lo, hi);
        for (int n = 0; n < 42; n++) begin
          r = $urandom_range(99);
          if (r < 70 && lo <= hi) rng = 16'($urandom_range(hi, lo));
          else if (r < 80) begin
            case ($urandom_range(3))
              0: rng = lo;
              1: rng = hi;
              2: rng = lo - 16'd1;
              default: rng = hi + 16'd1;
            endcase
          end else rng = 16'($urandom);
          queue_sample(rng, 12'($urandom_range(4095, 0)));
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: schedule empty, nothing held on the ports, nothing expected.
    do @(negedge clk);
    while (sched_q.size() != 0 || start || cfg_valid || pixel_q.size() != 0);
    // catch stray strobes after the last expected pixel
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== lidar_range_to_grid_pixel.f =====
src/lrg_pkg.sv
src/lrg_sine.sv
src/lrg_scale.sv
src/lidar_range_to_grid_pixel.sv
src/lrg_checker.sv
tb/tb.sv
